### design/tcw_pkg.sv
// tcw_pkg: constants, codes and types shared by the text console writer
// modules. It has no dependencies and is compiled first.

package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;
	localparam int ACT_W  = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
	localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'h0F;

	typedef enum logic [2:0] {
		CMD_PUT,
		CMD_NEWLINE,
		CMD_CLEAR,
		CMD_READ,
		CMD_READ_NONE,
		CMD_NOP
	} tcw_cmd_kind_t;

	typedef struct packed {
		tcw_cmd_kind_t       kind;
		logic [CHAR_W-1:0]   char_code;
		logic [ADDR_W-1:0]   rd_addr;
	} tcw_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_CLEAR,
		ST_RDWAIT
	} tcw_state_t;

endpackage

### design/tcw_if.sv
// tcw_if: valid/ready channel interfaces for requests, results and the
// color register write. Depends on tcw_pkg for field widths.

interface tcw_req_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::ACT_W-1:0]    action;
	logic [tcw_pkg::CHAR_W-1:0]   char_code;
	logic [tcw_pkg::ROW_W-1:0]    cell_row;
	logic [tcw_pkg::COL_W-1:0]    cell_col;

	modport source (output valid, action, char_code, cell_row, cell_col, input ready);
	modport sink   (input valid, action, char_code, cell_row, cell_col, output ready);
endinterface

interface tcw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::CELL_W-1:0]   cell_data;
	logic [tcw_pkg::ROW_W-1:0]    cursor_row;
	logic [tcw_pkg::COL_W-1:0]    cursor_col;
	logic                         scrolled;

	modport source (output valid, cell_data, cursor_row, cursor_col, scrolled, input ready);
	modport sink   (input valid, cell_data, cursor_row, cursor_col, scrolled, output ready);
endinterface

interface tcw_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::CHAR_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

### design/tcw_front.sv
// tcw_front: accepts request transfers, decodes them into commands and
// buffers them in a short queue. Depends on tcw_pkg and tcw_if.

module tcw_front (
	input  logic                    clk,
	input  logic                    arst_n,
	tcw_req_if.sink                 req,
	output logic                    cmd_valid,
	input  logic                    cmd_ready,
	output tcw_pkg::tcw_cmd_t       cmd
);

	tcw_pkg::tcw_cmd_t                dec;
	logic                             in_range;
	logic [tcw_pkg::ADDR_W-1:0]       row_base;
	logic                             push;
	logic                             pop;

	tcw_pkg::tcw_cmd_t                entry_q [tcw_pkg::QUEUE_DEPTH];
	logic [tcw_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [tcw_pkg::QCNT_W-1:0]       count_q;

	function automatic logic [tcw_pkg::QPTR_W-1:0] ptr_next(
		input logic [tcw_pkg::QPTR_W-1:0] p);
		if (p == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_comb begin
		in_range = (int'(req.cell_row) < tcw_pkg::ROWS)
			&& (int'(req.cell_col) < tcw_pkg::COLUMNS);
		row_base = tcw_pkg::ADDR_W'(req.cell_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
		dec.char_code = req.char_code;
		dec.rd_addr   = row_base + tcw_pkg::ADDR_W'(req.cell_col);
		case (req.action)
			tcw_pkg::ACT_PUT: begin
				dec.kind = (req.char_code == tcw_pkg::NEWLINE_CODE)
					? tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_PUT;
			end
			tcw_pkg::ACT_CLEAR: begin
				dec.kind = tcw_pkg::CMD_CLEAR;
			end
			tcw_pkg::ACT_READ: begin
				dec.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_READ_NONE;
			end
			default: begin
				dec.kind = tcw_pkg::CMD_NOP;
			end
		endcase
	end

	assign req.ready = (count_q != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

endmodule

### design/tcw_back.sv
// tcw_back: executes commands against the cell store, keeps the cursor and
// the color register, and holds the result register. Depends on tcw_pkg, tcw_if.

module tcw_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  tcw_pkg::tcw_cmd_t       cmd,
	tcw_rsp_if.source               rsp,
	tcw_cfg_if.sink                 cfg
);

	localparam logic [tcw_pkg::ADDR_W-1:0] SCROLL_LAST =
		tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS - 1);
	localparam logic [tcw_pkg::ADDR_W-1:0] BLANK_FIRST =
		tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
	localparam logic [tcw_pkg::ADDR_W-1:0] CELL_LAST =
		tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);

	tcw_pkg::tcw_state_t              state_q;
	tcw_pkg::tcw_state_t              state_d;

	logic [tcw_pkg::CELL_W-1:0]       mem [tcw_pkg::CELL_COUNT];
	logic [tcw_pkg::CELL_W-1:0]       rd_data_q;

	logic [tcw_pkg::ADDR_W-1:0]       k_q;
	logic [tcw_pkg::ADDR_W-1:0]       k_d;
	logic                             copy_v_s1;
	logic [tcw_pkg::ADDR_W-1:0]       copy_addr_s1;

	logic [tcw_pkg::ROW_W-1:0]        row_q;
	logic [tcw_pkg::COL_W-1:0]        col_q;
	logic [tcw_pkg::CHAR_W-1:0]       color_q;

	logic                             out_valid_q;
	logic [tcw_pkg::CELL_W-1:0]       out_data_q;
	logic [tcw_pkg::ROW_W-1:0]        out_row_q;
	logic [tcw_pkg::COL_W-1:0]        out_col_q;
	logic                             out_scr_q;

	logic                             out_free;
	logic                             start;
	logic                             done;
	logic                             is_move;
	logic                             last_col;
	logic                             bottom_row;
	logic                             wrap;
	logic                             do_scroll;
	logic [tcw_pkg::ROW_W-1:0]        next_row;
	logic [tcw_pkg::COL_W-1:0]        next_col;
	logic [tcw_pkg::ADDR_W-1:0]       put_addr;

	logic                             mem_we;
	logic [tcw_pkg::ADDR_W-1:0]       mem_wa;
	logic [tcw_pkg::CELL_W-1:0]       mem_wd;
	logic [tcw_pkg::ADDR_W-1:0]       mem_ra;
	logic [tcw_pkg::CELL_W-1:0]       blank_cell;

	assign out_free   = !out_valid_q || rsp.ready;
	assign start      = (state_q == tcw_pkg::ST_IDLE) && cmd_valid && out_free;
	assign blank_cell = {color_q, tcw_pkg::BLANK_CODE};

	// cursor update for put and newline
	always_comb begin
		is_move    = (cmd.kind == tcw_pkg::CMD_PUT) || (cmd.kind == tcw_pkg::CMD_NEWLINE);
		last_col   = (col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
		bottom_row = (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
		wrap       = (cmd.kind == tcw_pkg::CMD_NEWLINE) || last_col;
		do_scroll  = is_move && wrap && bottom_row;
		put_addr   = tcw_pkg::ADDR_W'(row_q) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
			+ tcw_pkg::ADDR_W'(col_q);
		if (do_scroll) begin
			next_row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
		end else if (wrap) begin
			next_row = row_q + 1'b1;
		end else begin
			next_row = row_q;
		end
		next_col = wrap ? '0 : col_q + 1'b1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::ST_IDLE: begin
				if (start) begin
					case (cmd.kind)
						tcw_pkg::CMD_PUT, tcw_pkg::CMD_NEWLINE: begin
							state_d = do_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_IDLE;
						end
						tcw_pkg::CMD_CLEAR: state_d = tcw_pkg::ST_CLEAR;
						tcw_pkg::CMD_READ:  state_d = tcw_pkg::ST_RDWAIT;
						default:            state_d = tcw_pkg::ST_IDLE;
					endcase
				end
			end
			tcw_pkg::ST_SCROLL: begin
				if (k_q == SCROLL_LAST) begin
					state_d = tcw_pkg::ST_BLANK;
				end
			end
			tcw_pkg::ST_BLANK: begin
				if (!copy_v_s1 && k_q == CELL_LAST) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_CLEAR: begin
				if (k_q == CELL_LAST) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_RDWAIT: state_d = tcw_pkg::ST_IDLE;
			default:            state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		done      = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = k_q;
		mem_wd    = blank_cell;
		mem_ra    = cmd.rd_addr;
		k_d       = k_q;
		case (state_q)
			tcw_pkg::ST_IDLE: begin
				cmd_ready = start;
				k_d       = '0;
				if (start) begin
					if (cmd.kind == tcw_pkg::CMD_PUT) begin
						mem_we = 1'b1;
						mem_wa = put_addr;
						mem_wd = {color_q, cmd.char_code};
					end
					done = (is_move && !do_scroll) || (cmd.kind == tcw_pkg::CMD_READ_NONE)
						|| (cmd.kind == tcw_pkg::CMD_NOP);
				end
			end
			tcw_pkg::ST_SCROLL: begin
				// read one row below, write the registered data back in the following cycle
				mem_ra = k_q + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
				mem_we = copy_v_s1;
				mem_wa = copy_addr_s1;
				mem_wd = rd_data_q;
				k_d    = (k_q == SCROLL_LAST) ? BLANK_FIRST : k_q + 1'b1;
			end
			tcw_pkg::ST_BLANK: begin
				mem_we = 1'b1;
				if (copy_v_s1) begin
					mem_wa = copy_addr_s1;
					mem_wd = rd_data_q;
				end else begin
					k_d  = k_q + 1'b1;
					done = (k_q == CELL_LAST);
				end
			end
			tcw_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				k_d    = k_q + 1'b1;
				done   = (k_q == CELL_LAST);
			end
			tcw_pkg::ST_RDWAIT: begin
				done = 1'b1;
			end
			default: begin
				k_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[mem_ra];
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_IDLE;
			k_q         <= '0;
			copy_v_s1   <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			color_q     <= tcw_pkg::COLOR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			k_q       <= k_d;
			copy_v_s1 <= (state_q == tcw_pkg::ST_SCROLL);
			if (cfg.valid) begin
				color_q <= cfg.data;
			end
			if (start && is_move) begin
				row_q <= next_row;
				col_q <= next_col;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result fields load at command start, the read data in the cycle after
	always_ff @(posedge clk) begin
		copy_addr_s1 <= k_q;
		if (start) begin
			out_data_q <= '0;
			out_row_q  <= is_move ? next_row : row_q;
			out_col_q  <= is_move ? next_col : col_q;
			out_scr_q  <= do_scroll;
		end else if (state_q == tcw_pkg::ST_RDWAIT) begin
			out_data_q <= rd_data_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cell_data  = out_data_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.scrolled   = out_scr_q;

endmodule

### design/text_console_writer_core.sv
// text_console_writer_core: top level of the text console writer.
// Depends on tcw_pkg, tcw_if, tcw_front and tcw_back.
//
//   channel  dir  payload                                        transfer when
//   req      in   action, char_code, cell_row, cell_col          req.valid & req.ready
//   rsp      out  cell_data, cursor_row, cursor_col, scrolled    rsp.valid & rsp.ready
//   cfg      in   data (text color)                              cfg.valid & cfg.ready
//
// in the back end, put or newline with no scroll, unused action and out-of-range read
// finish at start; read passes ST_RDWAIT (registered store read); clear writes every
// cell; a scroll copies rows up and blanks the bottom row, at most one store write per
// cycle over the single write port. the front queue takes up to QUEUE_DEPTH requests
// while a result waits in the output register. arst_n clears cursor and control and
// sets color to COLOR_RESET; the cell store has no reset. cfg is always ready.

module text_console_writer_core (
	input  logic        clk,
	input  logic        arst_n,
	tcw_req_if.sink     req,
	tcw_rsp_if.source   rsp,
	tcw_cfg_if.sink     cfg
);

	logic                 cmd_valid;
	logic                 cmd_ready;
	tcw_pkg::tcw_cmd_t    cmd;

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	tcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp       (rsp),
		.cfg       (cfg)
	);

endmodule
